[rtl/core/utf8_decoder_core_macros.svh]
// assertion macros shared by the utf8 decoder rtl
// used by files that take it with an include; no other dependencies
`ifndef UTF8_DECODER_CORE_MACROS_SVH
`define UTF8_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define UTF8D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define UTF8D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder assertion failed");

`endif

[rtl/core/utf8d_pkg.sv]
// types, constants and helper functions for the utf8 decoder
// no dependencies
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam logic [20:0] REPL_CP     = 21'h00FFFD;
  localparam logic [20:0] MIN_CP2     = 21'h000080;
  localparam logic [20:0] MIN_CP3     = 21'h000800;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] MIN_CP4     = 21'h010000;
  localparam logic [20:0] MAX_CP      = 21'h10FFFF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // one queued job: a run of replacements, then an optional decoded code point
  typedef struct packed {
    logic [2:0]  n_repl;
    logic        tail_valid;
    logic [20:0] tail_cp;
    logic [2:0]  tail_len;
  } job_t;

  function automatic logic value_ok(input logic [2:0] total, input logic [20:0] cp);
    logic ok;
    begin
      if (total == 3'd2) begin
        ok = (cp >= MIN_CP2);
      end else if (total == 3'd3) begin
        ok = (cp >= MIN_CP3) && !((cp >= SURR_LO) && (cp <= SURR_HI));
      end else begin
        ok = (cp >= MIN_CP4) && (cp <= MAX_CP);
      end
      return ok;
    end
  endfunction

endpackage

[rtl/core/utf8d_front.sv]
// front end: takes bytes, tracks the open sequence, emits at most one job per byte
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              end_of_text,
  output logic              push,
  output utf8d_pkg::job_t   job
);

  logic [2:0]  expected_total;
  logic [2:0]  expected_total_next;
  logic [1:0]  held_count;
  logic [1:0]  held_count_next;
  logic [20:0] partial_value;
  logic [20:0] partial_value_next;

  logic        seq_open;
  logic        is_cont;
  logic [2:0]  held_ext;
  logic [20:0] cp_ext;
  logic        fresh_en;
  logic [2:0]  base_repl;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign seq_open = (expected_total >= 3'd2) && (expected_total <= 3'd4);
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign held_ext = {1'b0, held_count} + 3'd1;
  assign cp_ext   = {partial_value[14:0], data_byte[5:0]};

  always_comb begin
    job                 = '0;
    expected_total_next = expected_total;
    held_count_next     = held_count;
    partial_value_next  = partial_value;
    fresh_en            = 1'b0;
    base_repl           = 3'd0;
    if (seq_open) begin
      if (is_cont) begin
        if ((held_ext + 3'd1) >= expected_total) begin
          expected_total_next = 3'd0;
          held_count_next     = 2'd0;
          partial_value_next  = '0;
          if (utf8d_pkg::value_ok(expected_total, cp_ext)) begin
            job.tail_valid = 1'b1;
            job.tail_cp    = cp_ext;
            job.tail_len   = expected_total;
          end else begin
            job.n_repl = held_ext + 3'd1;
          end
        end else if (end_of_text) begin
          expected_total_next = 3'd0;
          held_count_next     = 2'd0;
          partial_value_next  = '0;
          job.n_repl          = held_ext + 3'd1;
        end else begin
          held_count_next    = held_ext[1:0];
          partial_value_next = cp_ext;
        end
      end else begin
        base_repl           = held_ext;
        expected_total_next = 3'd0;
        held_count_next     = 2'd0;
        partial_value_next  = '0;
        fresh_en            = 1'b1;
      end
    end else begin
      fresh_en = 1'b1;
    end

    if (fresh_en) begin
      job.n_repl = base_repl;
      priority if (!data_byte[7]) begin
        job.tail_valid = 1'b1;
        job.tail_cp    = {13'd0, data_byte};
        job.tail_len   = 3'd1;
      end else if (end_of_text || data_byte[6] == 1'b0 || data_byte[7:3] == 5'b11111) begin
        // bad lead, or a lead cut off by the end of the text
        job.n_repl = base_repl + 3'd1;
      end else if (data_byte[5] == 1'b0) begin
        expected_total_next = 3'd2;
        held_count_next     = 2'd0;
        partial_value_next  = {16'd0, data_byte[4:0]};
      end else if (data_byte[4] == 1'b0) begin
        expected_total_next = 3'd3;
        held_count_next     = 2'd0;
        partial_value_next  = {17'd0, data_byte[3:0]};
      end else begin
        expected_total_next = 3'd4;
        held_count_next     = 2'd0;
        partial_value_next  = {18'd0, data_byte[2:0]};
      end
    end
  end

  assign push = accept && ((job.n_repl != 3'd0) || job.tail_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_total <= 3'd0;
      held_count     <= 2'd0;
      partial_value  <= '0;
    end else if (accept) begin
      expected_total <= expected_total_next;
      held_count     <= held_count_next;
      partial_value  <= partial_value_next;
    end
  end

endmodule

[rtl/core/utf8d_queue.sv]
// short job queue between front and back ends
// depends on utf8d_pkg and utf8_decoder_core_macros.svh
`timescale 1ns / 1ps

`include "utf8_decoder_core_macros.svh"

module utf8d_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  utf8d_pkg::job_t push_job,
  input  logic            pop,
  output utf8d_pkg::job_t head,
  output logic            empty,
  output logic            full
);

  localparam int unsigned CNT_W = utf8d_pkg::QPTR_W + 1;

  utf8d_pkg::job_t              mem [utf8d_pkg::QUEUE_DEPTH];
  logic [utf8d_pkg::QPTR_W-1:0] wptr;
  logic [utf8d_pkg::QPTR_W-1:0] rptr;
  logic [CNT_W-1:0]             count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(utf8d_pkg::QUEUE_DEPTH));
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `UTF8D_ASSERT_NOW(a_no_overflow, push, !full)
  `UTF8D_ASSERT_NOW(a_no_underflow, pop, !empty)
  `UTF8D_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1)
  `UTF8D_ASSERT_NOW(a_job_nonempty, push, push_job.n_repl != 3'd0 || push_job.tail_valid)

endmodule

[rtl/core/utf8d_back.sv]
// back end: expands each job into result words through an output register
// depends on utf8d_pkg and utf8_decoder_core_macros.svh
`timescale 1ns / 1ps

`include "utf8_decoder_core_macros.svh"

module utf8d_back (
  input  logic            clk,
  input  logic            rst,
  input  utf8d_pkg::job_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [20:0]     code_point,
  output logic [2:0]      seq_length,
  output logic            is_replacement,
  output logic            last_of_run
);

  logic [2:0] rep_done;
  logic [2:0] rep_done_next;
  logic       adv;
  logic       go;
  logic       in_repl;
  logic       last;

  assign adv     = !out_valid || out_ready;
  assign go      = !empty && adv;
  assign in_repl = (rep_done < head.n_repl);
  assign last    = in_repl ? (((rep_done + 3'd1) == head.n_repl) && !head.tail_valid) : 1'b1;
  assign pop     = go && last;

  always_comb begin
    rep_done_next = rep_done;
    if (pop) begin
      rep_done_next = 3'd0;
    end else if (go && in_repl) begin
      rep_done_next = rep_done + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_done  <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      rep_done <= rep_done_next;
      if (adv) begin
        out_valid <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      last_of_run <= last;
      if (in_repl) begin
        code_point     <= utf8d_pkg::REPL_CP;
        seq_length     <= 3'd1;
        is_replacement <= 1'b1;
      end else begin
        code_point     <= head.tail_cp;
        seq_length     <= head.tail_len;
        is_replacement <= 1'b0;
      end
    end
  end

  `UTF8D_ASSERT_NOW(a_count_in_range, !empty, rep_done <= head.n_repl)
  `UTF8D_ASSERT_NEXT(a_run_restarts, pop, rep_done == 3'd0)
  `UTF8D_ASSERT_NOW(a_tail_len_ok, !empty && head.tail_valid,
                    head.tail_len >= 3'd1 && head.tail_len <= 3'd4)

endmodule

[rtl/core/utf8_decoder_core.sv]
// utf8 decoder top level: front end, job queue, back end
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
//
// channel  dir  tdata                                tlast / tuser
// s_*      in   [7:0] data_byte                      tlast = end_of_text
// m_*      out  [20:0] code_point [23:21] seq_length tlast = last_of_run
//                                                    tuser = is_replacement
//
// one byte per cycle is taken while the job queue has room
// each byte gives 0 to 4 words; the back end sends one word per cycle while m_tready is high,
// so a byte that gives n words holds the back end until all n words are sent
// a four-entry job queue absorbs replacement bursts; s_tready drops when it fills
// a byte's first word passes through the job queue and the back end output register; rst clears the sequence and queue
`timescale 1ns / 1ps

module utf8_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // code_point, seq_length
  output logic        m_tuser,   // is_replacement
  output logic        m_tlast
);

  utf8d_pkg::job_t push_job;
  utf8d_pkg::job_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  logic [20:0]     code_point;
  logic [2:0]      seq_length;

  assign s_tready = !full;

  utf8d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .data_byte   (s_tdata),
    .end_of_text (s_tlast),
    .push        (push),
    .job         (push_job)
  );

  utf8d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  utf8d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .code_point     (code_point),
    .seq_length     (seq_length),
    .is_replacement (m_tuser),
    .last_of_run    (m_tlast)
  );

  assign m_tdata = {seq_length, code_point};

endmodule
